// ----- design/i8080ss_pkg.sv -----
// shared types, constants and helper functions of the 8080 subset step unit
package i8080ss_pkg;

  localparam int unsigned MemBytes = 65536;
  localparam int unsigned MemAw    = $clog2(MemBytes);

  // result status codes
  localparam logic [1:0] StExec    = 2'd0;
  localparam logic [1:0] StUnimpl  = 2'd1;
  localparam logic [1:0] StLoaded  = 2'd2;

  // item opcodes
  localparam logic OpLoad = 1'b0;
  localparam logic OpExec = 1'b1;

  // register codes of the instruction set
  localparam logic [2:0] RegB = 3'd0;
  localparam logic [2:0] RegC = 3'd1;
  localparam logic [2:0] RegD = 3'd2;
  localparam logic [2:0] RegE = 3'd3;
  localparam logic [2:0] RegH = 3'd4;
  localparam logic [2:0] RegL = 3'd5;
  localparam logic [2:0] RegM = 3'd6;
  localparam logic [2:0] RegA = 3'd7;

  localparam logic [15:0] SpReset = 16'hF000;

  typedef struct packed {
    logic        opcode;
    logic [15:0] address;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] prog_counter;
    logic [7:0]  acc;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [15:0] stack_ptr;
    logic [4:0]  flag_bits;
    logic [4:0]  cycles;
  } out_word_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic             en;
    logic             we;
    logic [MemAw-1:0] addr;
    logic [7:0]       wdata;
  } mem_req_t;

  // sign, zero and parity of a byte, packed as {s, z, p}
  function automatic logic [2:0] szp(input logic [7:0] v);
    szp = {v[7], (v == 8'h00), ~(^v)};
  endfunction

endpackage

// ----- design/i8080ss_ifs.sv -----
// valid/ready channel interfaces for input and result words
interface i8080ss_in_if;
  logic                  valid;
  logic                  ready;
  i8080ss_pkg::in_word_t word;
  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

interface i8080ss_out_if;
  logic                   valid;
  logic                   ready;
  i8080ss_pkg::out_word_t word;
  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

// ----- design/i8080ss_ram.sv -----
// generic single-port synchronous ram, registered read
module i8080ss_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write or registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// ----- design/i8080ss_core.sv -----
// instruction sequencer: register file, alu and memory access steps
module i8080ss_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  i8080ss_in_if.sink            in_i,
  i8080ss_out_if.source         out_o,
  output i8080ss_pkg::mem_req_t mem_req_o,
  input  logic [7:0]            mem_rdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEC    = 3'd1;
  localparam logic [2:0] S_OPLO   = 3'd2;
  localparam logic [2:0] S_OPHI   = 3'd3;
  localparam logic [2:0] S_MEMRD  = 3'd4;
  localparam logic [2:0] S_MEMRD2 = 3'd5;
  localparam logic [2:0] S_MEMW2  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [15:0] pc_q, pc_d, sp_q, sp_d, addr_q, addr_d;
  logic [7:0]  a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, e_q, e_d, h_q, h_d, l_q, l_d;
  logic [4:0]  flags_q, flags_d, cyc_q, cyc_d;
  logic [1:0]  status_q, status_d;
  logic [7:0]  op_q, op_d, lo_q, lo_d;
  logic        out_valid_q, out_valid_d;
  i8080ss_pkg::out_word_t out_word_q, out_word_d;

  logic [7:0]  op;
  logic [2:0]  rcode, scode;
  logic [1:0]  pcode;
  logic [15:0] hl, rp_val, mem_addr;
  logic [7:0]  r_val, s_val;
  logic        mem_en, mem_we;
  logic [7:0]  mem_wdata;
  logic        wr_en;
  logic [2:0]  wr_code;
  logic [7:0]  wr_val;
  logic [16:0] dad_sum;
  logic [7:0]  alu_v, alu_n;
  logic [2:0]  f_szp;
  logic        daa_lo, daa_hi;
  logic [7:0]  daa_corr;
  logic [4:0]  daa_nib;

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_word_q;

  assign mem_req_o.en    = mem_en;
  assign mem_req_o.we    = mem_we;
  assign mem_req_o.addr  = mem_addr[i8080ss_pkg::MemAw-1:0];
  assign mem_req_o.wdata = mem_wdata;

  // opcode fields, straight from memory in the decode step
  assign op    = (state_q == S_DEC) ? mem_rdata_i : op_q;
  assign rcode = op[5:3];
  assign scode = op[2:0];
  assign pcode = op[5:4];
  assign hl    = {h_q, l_q};

  // register read by code
  always_comb begin
    case (rcode)
      i8080ss_pkg::RegB: r_val = b_q;
      i8080ss_pkg::RegC: r_val = c_q;
      i8080ss_pkg::RegD: r_val = d_q;
      i8080ss_pkg::RegE: r_val = e_q;
      i8080ss_pkg::RegH: r_val = h_q;
      i8080ss_pkg::RegL: r_val = l_q;
      i8080ss_pkg::RegA: r_val = a_q;
      default:           r_val = mem_rdata_i;
    endcase
    case (scode)
      i8080ss_pkg::RegB: s_val = b_q;
      i8080ss_pkg::RegC: s_val = c_q;
      i8080ss_pkg::RegD: s_val = d_q;
      i8080ss_pkg::RegE: s_val = e_q;
      i8080ss_pkg::RegH: s_val = h_q;
      i8080ss_pkg::RegL: s_val = l_q;
      i8080ss_pkg::RegA: s_val = a_q;
      default:           s_val = mem_rdata_i;
    endcase
    case (pcode)
      2'd0:    rp_val = {b_q, c_q};
      2'd1:    rp_val = {d_q, e_q};
      2'd2:    rp_val = hl;
      default: rp_val = sp_q;
    endcase
  end

  // inr/dcr operand, daa correction and pair add
  assign alu_v    = (state_q == S_MEMRD) ? mem_rdata_i : r_val;
  assign alu_n    = scode[0] ? (alu_v - 8'd1) : (alu_v + 8'd1);
  assign f_szp    = i8080ss_pkg::szp(alu_n);
  assign dad_sum  = {1'b0, hl} + {1'b0, rp_val};
  assign daa_lo   = (a_q[3:0] > 4'd9) || flags_q[2];
  assign daa_hi   = (a_q > 8'h99) || flags_q[0];
  assign daa_corr = {(daa_hi ? 4'h6 : 4'h0), (daa_lo ? 4'h6 : 4'h0)};
  assign daa_nib  = {1'b0, a_q[3:0]} + {1'b0, daa_corr[3:0]};

  // sequencer next state
  always_comb begin
    logic [7:0] dv;
    logic [2:0] dv_f;
    state_d     = state_q;
    pc_d        = pc_q;
    sp_d        = sp_q;
    addr_d      = addr_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q; h_d = h_q; l_d = l_q;
    flags_d     = flags_q;
    cyc_d       = cyc_q;
    status_d    = status_q;
    op_d        = op_q;
    lo_d        = lo_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_word_d  = out_word_q;
    mem_en      = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = pc_q;
    mem_wdata   = a_q;
    wr_en       = 1'b0;
    wr_code     = rcode;
    wr_val      = mem_rdata_i;
    dv          = a_q + daa_corr;
    dv_f        = i8080ss_pkg::szp(dv);

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          mem_en = 1'b1;
          if (in_i.word.opcode == i8080ss_pkg::OpLoad) begin
            mem_we    = 1'b1;
            mem_addr  = in_i.word.address;
            mem_wdata = in_i.word.data;
            status_d  = i8080ss_pkg::StLoaded;
            cyc_d     = 5'd0;
            state_d   = S_DONE;
          end else begin
            pc_d    = pc_q + 16'd1;
            state_d = S_DEC;
          end
        end
      end

      S_DEC: begin
        op_d     = op;
        status_d = i8080ss_pkg::StExec;
        cyc_d    = 5'd0;
        state_d  = S_DONE;
        if (op[7:6] == 2'b00) begin
          unique case (scode)
            3'd0: cyc_d = 5'd4;
            3'd1: begin
              cyc_d = 5'd10;
              if (op[3]) begin
                flags_d[0] = dad_sum[16];
                h_d = dad_sum[15:8];
                l_d = dad_sum[7:0];
              end else begin
                mem_en  = 1'b1;
                pc_d    = pc_q + 16'd1;
                state_d = S_OPLO;
              end
            end
            3'd2: begin
              mem_en = 1'b1;
              if (!op[5]) begin
                cyc_d    = 5'd7;
                mem_addr = rp_val;
                if (op[3]) begin
                  state_d = S_MEMRD;
                end else begin
                  mem_we = 1'b1;
                end
              end else begin
                cyc_d   = op[4] ? 5'd13 : 5'd16;
                pc_d    = pc_q + 16'd1;
                state_d = S_OPLO;
              end
            end
            3'd3: begin
              cyc_d = 5'd5;
              case (pcode)
                2'd0: {b_d, c_d} = op[3] ? rp_val - 16'd1 : rp_val + 16'd1;
                2'd1: {d_d, e_d} = op[3] ? rp_val - 16'd1 : rp_val + 16'd1;
                2'd2: {h_d, l_d} = op[3] ? rp_val - 16'd1 : rp_val + 16'd1;
                default: sp_d    = op[3] ? rp_val - 16'd1 : rp_val + 16'd1;
              endcase
            end
            3'd4, 3'd5: begin
              if (rcode == i8080ss_pkg::RegM) begin
                cyc_d    = 5'd10;
                mem_en   = 1'b1;
                mem_addr = hl;
                state_d  = S_MEMRD;
              end else begin
                cyc_d   = 5'd5;
                flags_d = {f_szp[2:1], (scode[0] ? (alu_v[3:0] != 4'h0)
                                                 : (alu_v[3:0] == 4'hF)),
                           f_szp[0], flags_q[0]};
                wr_en   = 1'b1;
                wr_val  = alu_n;
              end
            end
            3'd6: begin
              cyc_d   = (rcode == i8080ss_pkg::RegM) ? 5'd10 : 5'd7;
              mem_en  = 1'b1;
              pc_d    = pc_q + 16'd1;
              state_d = S_OPLO;
            end
            default: begin
              cyc_d = 5'd4;
              unique case (rcode)
                3'd0: begin flags_d[0] = a_q[7]; a_d = {a_q[6:0], a_q[7]}; end
                3'd1: begin flags_d[0] = a_q[0]; a_d = {a_q[0], a_q[7:1]}; end
                3'd2: begin flags_d[0] = a_q[7]; a_d = {a_q[6:0], flags_q[0]}; end
                3'd3: begin flags_d[0] = a_q[0]; a_d = {flags_q[0], a_q[7:1]}; end
                3'd4: begin
                  a_d     = dv;
                  flags_d = {dv_f[2:1], daa_nib[4], dv_f[0], daa_hi};
                end
                3'd5: a_d = ~a_q;
                3'd6: flags_d[0] = 1'b1;
                default: flags_d[0] = ~flags_q[0];
              endcase
            end
          endcase
        end else if (op[7:6] == 2'b01) begin
          if (op == 8'h76) begin
            status_d = i8080ss_pkg::StUnimpl;
          end else if (scode == i8080ss_pkg::RegM) begin
            cyc_d    = 5'd7;
            mem_en   = 1'b1;
            mem_addr = hl;
            state_d  = S_MEMRD;
          end else if (rcode == i8080ss_pkg::RegM) begin
            cyc_d     = 5'd7;
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = hl;
            mem_wdata = s_val;
          end else begin
            cyc_d  = 5'd5;
            wr_en  = 1'b1;
            wr_val = s_val;
          end
        end else begin
          unique case (op) inside
            8'hCB, 8'hD9, 8'hDD, 8'hED, 8'hFD: cyc_d = 5'd4;
            default: status_d = i8080ss_pkg::StUnimpl;
          endcase
        end
      end

      S_OPLO: begin
        lo_d = mem_rdata_i;
        if (op_q[2:0] == 3'd6) begin
          state_d = S_DONE;
          if (rcode == i8080ss_pkg::RegM) begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = hl;
            mem_wdata = mem_rdata_i;
          end else begin
            wr_en = 1'b1;
          end
        end else begin
          mem_en  = 1'b1;
          pc_d    = pc_q + 16'd1;
          state_d = S_OPHI;
        end
      end

      S_OPHI: begin
        addr_d  = {mem_rdata_i, lo_q};
        state_d = S_DONE;
        if (op_q[2:0] == 3'd1) begin
          case (pcode)
            2'd0: {b_d, c_d} = {mem_rdata_i, lo_q};
            2'd1: {d_d, e_d} = {mem_rdata_i, lo_q};
            2'd2: {h_d, l_d} = {mem_rdata_i, lo_q};
            default: sp_d    = {mem_rdata_i, lo_q};
          endcase
        end else begin
          mem_en   = 1'b1;
          mem_addr = {mem_rdata_i, lo_q};
          if (op_q[3]) begin
            state_d = S_MEMRD;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = op_q[4] ? a_q : l_q;
            if (!op_q[4]) begin
              state_d = S_MEMW2;
            end
          end
        end
      end

      S_MEMRD: begin
        state_d = S_DONE;
        if (op_q[6]) begin
          wr_en = 1'b1;
        end else if (op_q[2:0] == 3'd2) begin
          if (op_q[5:4] == 2'd2) begin
            l_d      = mem_rdata_i;
            mem_en   = 1'b1;
            mem_addr = addr_q + 16'd1;
            state_d  = S_MEMRD2;
          end else begin
            a_d = mem_rdata_i;
          end
        end else begin
          flags_d   = {f_szp[2:1], (scode[0] ? (alu_v[3:0] != 4'h0)
                                             : (alu_v[3:0] == 4'hF)),
                       f_szp[0], flags_q[0]};
          mem_en    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = hl;
          mem_wdata = alu_n;
        end
      end

      S_MEMRD2: begin
        h_d     = mem_rdata_i;
        state_d = S_DONE;
      end

      S_MEMW2: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = addr_q + 16'd1;
        mem_wdata = h_q;
        state_d   = S_DONE;
      end

      default: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_word_d  = '{status: status_q, prog_counter: pc_q, acc: a_q,
                          reg_b: b_q, reg_c: c_q, reg_d: d_q, reg_e: e_q,
                          reg_h: h_q, reg_l: l_q, stack_ptr: sp_q,
                          flag_bits: flags_q, cycles: cyc_q};
          state_d     = S_IDLE;
        end
      end
    endcase

    // single register write port
    if (wr_en) begin
      case (wr_code)
        i8080ss_pkg::RegB: b_d = wr_val;
        i8080ss_pkg::RegC: c_d = wr_val;
        i8080ss_pkg::RegD: d_d = wr_val;
        i8080ss_pkg::RegE: e_d = wr_val;
        i8080ss_pkg::RegH: h_d = wr_val;
        i8080ss_pkg::RegL: l_d = wr_val;
        i8080ss_pkg::RegA: a_d = wr_val;
        default: ;
      endcase
    end
  end

  // control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pc_q        <= 16'h0000;
      sp_q        <= i8080ss_pkg::SpReset;
      a_q <= 8'h00; b_q <= 8'h00; c_q <= 8'h00; d_q <= 8'h00;
      e_q <= 8'h00; h_q <= 8'h00; l_q <= 8'h00;
      flags_q     <= 5'h00;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pc_q        <= pc_d;
      sp_q        <= sp_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
      e_q <= e_d; h_q <= h_d; l_q <= l_d;
      flags_q     <= flags_d;
    end
  end

  // per-item working registers and result word
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    cyc_q      <= cyc_d;
    status_q   <= status_d;
    op_q       <= op_d;
    lo_q       <= lo_d;
    out_word_q <= out_word_d;
  end

endmodule

// ----- design/i8080_core_subset_step_unit.sv -----
// load item: one memory write, then retire; execute item: fetch, up to two
// operand bytes and two data bytes through the single memory port, then retire
// one item in work at a time; the result register lets the next item start
// while a result still waits to be taken
// rst_ni (async, active low) sets pc 0, sp 0xf000, registers and flags 0;
// memory content is undefined until written, no clearing pass
module i8080_core_subset_step_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  i8080ss_in_if.sink    in_i,
  i8080ss_out_if.source out_o
);

  i8080ss_pkg::mem_req_t mem_req;
  logic [7:0]            mem_rdata;

  // sequencer
  i8080ss_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // program and data memory
  i8080ss_ram #(
    .Depth (i8080ss_pkg::MemBytes),
    .Width (8)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- sim/tb_i8080_core_subset_step_unit.sv -----
// self-checking testbench of the 8080 subset step unit
module tb_i8080_core_subset_step_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import i8080ss_pkg::*;

  // flag bit positions
  localparam int FlS  = 4;
  localparam int FlZ  = 3;
  localparam int FlAc = 2;
  localparam int FlP  = 1;
  localparam int FlCy = 0;

  // opcodes and accumulator group selects
  localparam logic [7:0] OpcHlt = 8'h76;
  localparam logic [7:0] OpcNopCb = 8'hCB;
  localparam logic [7:0] OpcNopD9 = 8'hD9;
  localparam logic [7:0] OpcNopDd = 8'hDD;
  localparam logic [7:0] OpcNopEd = 8'hED;
  localparam logic [7:0] OpcNopFd = 8'hFD;
  localparam logic [2:0] AccRlc = 3'd0;
  localparam logic [2:0] AccRrc = 3'd1;
  localparam logic [2:0] AccRal = 3'd2;
  localparam logic [2:0] AccRar = 3'd3;
  localparam logic [2:0] AccDaa = 3'd4;
  localparam logic [2:0] AccCma = 3'd5;
  localparam logic [2:0] AccStc = 3'd6;

  localparam int RandWords = 625;
  localparam int CycleLimit = 400000;
  localparam int LongStall = 300;

  typedef struct packed {
    in_word_t  w;
    logic      fixed;
    out_word_t want;
  } stim_row_t;

  localparam out_word_t NoWant = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  i8080ss_in_if  in_if();
  i8080ss_out_if out_if();

  i8080_core_subset_step_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #2 clk_i = ~clk_i;

  // architectural state mirrored by the predictor
  logic [7:0]  mem_img [65536];
  bit          mem_set [65536];
  logic [15:0] pc_q;
  logic [15:0] sp_q;
  logic [7:0]  regs_q [8];
  logic [4:0]  flags_q;

  out_word_t exp_q[$];
  int  mism_cnt = 0;
  int  cycle_cnt = 0;
  int  sent_cnt = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  stall_left = 0;
  bit  stall_req = 1'b0;

  function automatic void mem_write(logic [15:0] a, logic [7:0] v);
    mem_img[a] = v;
    mem_set[a] = 1'b1;
  endfunction

  function automatic logic [7:0] next_byte();
    logic [7:0] v;
    v = mem_img[pc_q];
    pc_q = pc_q + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] hl_pair();
    return {regs_q[RegH], regs_q[RegL]};
  endfunction

  function automatic logic [15:0] pair_rd(logic [1:0] p);
    case (p)
      2'd0: return {regs_q[RegB], regs_q[RegC]};
      2'd1: return {regs_q[RegD], regs_q[RegE]};
      2'd2: return hl_pair();
      default: return sp_q;
    endcase
  endfunction

  function automatic void pair_wr(logic [1:0] p, logic [15:0] v);
    case (p)
      2'd0: begin regs_q[RegB] = v[15:8]; regs_q[RegC] = v[7:0]; end
      2'd1: begin regs_q[RegD] = v[15:8]; regs_q[RegE] = v[7:0]; end
      2'd2: begin regs_q[RegH] = v[15:8]; regs_q[RegL] = v[7:0]; end
      default: sp_q = v;
    endcase
  endfunction

  function automatic logic [7:0] reg_rd(logic [2:0] c);
    if (c == RegM) return mem_img[hl_pair()];
    return regs_q[c];
  endfunction

  function automatic void reg_wr(logic [2:0] c, logic [7:0] v);
    if (c == RegM) mem_write(hl_pair(), v);
    else regs_q[c] = v;
  endfunction

  function automatic void sign_zero_parity(logic [7:0] v);
    flags_q[FlS] = v[7];
    flags_q[FlZ] = (v == 8'h00);
    flags_q[FlP] = ~(^v);
  endfunction

  // rotates, decimal adjust, complement and carry ops
  function automatic void acc_group(logic [2:0] sel);
    logic [7:0] a, corr;
    logic cy;
    a = regs_q[RegA];
    cy = flags_q[FlCy];
    corr = 8'h00;
    case (sel)
      AccRlc: begin flags_q[FlCy] = a[7]; a = {a[6:0], a[7]}; end
      AccRrc: begin flags_q[FlCy] = a[0]; a = {a[0], a[7:1]}; end
      AccRal: begin flags_q[FlCy] = a[7]; a = {a[6:0], cy}; end
      AccRar: begin flags_q[FlCy] = a[0]; a = {cy, a[7:1]}; end
      AccDaa: begin
        if (a[3:0] > 4'd9 || flags_q[FlAc]) corr[3:0] = 4'h6;
        if (a > 8'h99 || cy) begin
          corr[7:4] = 4'h6;
          cy = 1'b1;
        end
        flags_q[FlAc] = ({1'b0, a[3:0]} + {1'b0, corr[3:0]}) > 5'd15;
        a = a + corr;
        flags_q[FlCy] = cy;
        sign_zero_parity(a);
      end
      AccCma: a = ~a;
      AccStc: flags_q[FlCy] = 1'b1;
      default: flags_q[FlCy] = ~cy;
    endcase
    regs_q[RegA] = a;
  endfunction

  // opcodes 0x00-0x3f, returns the cycle count
  function automatic logic [4:0] low_block(logic [7:0] op);
    logic [1:0] p;
    logic [2:0] r;
    logic [7:0] lo, hi, v;
    logic [15:0] addr;
    logic [16:0] sum;
    p = op[5:4];
    r = op[5:3];
    case (op[2:0])
      3'd0: return 5'd4;
      3'd1: begin
        if (op[3]) begin
          sum = {1'b0, hl_pair()} + {1'b0, pair_rd(p)};
          flags_q[FlCy] = sum[16];
          pair_wr(2'd2, sum[15:0]);
        end else begin
          lo = next_byte();
          hi = next_byte();
          pair_wr(p, {hi, lo});
        end
        return 5'd10;
      end
      3'd2: begin
        if (!p[1]) begin
          if (op[3]) regs_q[RegA] = mem_img[pair_rd(p)];
          else mem_write(pair_rd(p), regs_q[RegA]);
          return 5'd7;
        end
        lo = next_byte();
        hi = next_byte();
        addr = {hi, lo};
        if (p == 2'd2) begin
          if (op[3]) begin
            regs_q[RegL] = mem_img[addr];
            regs_q[RegH] = mem_img[addr + 16'd1];
          end else begin
            mem_write(addr, regs_q[RegL]);
            mem_write(addr + 16'd1, regs_q[RegH]);
          end
          return 5'd16;
        end
        if (op[3]) regs_q[RegA] = mem_img[addr];
        else mem_write(addr, regs_q[RegA]);
        return 5'd13;
      end
      3'd3: begin
        if (op[3]) pair_wr(p, pair_rd(p) - 16'd1);
        else pair_wr(p, pair_rd(p) + 16'd1);
        return 5'd5;
      end
      3'd4, 3'd5: begin
        v = reg_rd(r);
        if (op[0]) begin
          flags_q[FlAc] = (v[3:0] != 4'h0);
          v = v - 8'd1;
        end else begin
          flags_q[FlAc] = (v[3:0] == 4'hF);
          v = v + 8'd1;
        end
        sign_zero_parity(v);
        reg_wr(r, v);
        return (r == RegM) ? 5'd10 : 5'd5;
      end
      3'd6: begin
        v = next_byte();
        reg_wr(r, v);
        return (r == RegM) ? 5'd10 : 5'd7;
      end
      default: begin
        acc_group(r);
        return 5'd4;
      end
    endcase
  endfunction

  // expected result of one word, updates the mirrored state
  function automatic out_word_t step_core(in_word_t w);
    out_word_t res;
    logic [7:0] op;
    res = '0;
    if (w.opcode == OpLoad) begin
      mem_write(w.address, w.data);
      res.status = StLoaded;
    end else begin
      op = next_byte();
      res.status = StExec;
      if (op < 8'h40) begin
        res.cycles = low_block(op);
      end else if (op < 8'h80) begin
        if (op == OpcHlt) begin
          res.status = StUnimpl;
        end else begin
          reg_wr(op[5:3], reg_rd(op[2:0]));
          res.cycles = (op[5:3] == RegM || op[2:0] == RegM) ? 5'd7 : 5'd5;
        end
      end else if (op == OpcNopCb || op == OpcNopD9 || op == OpcNopDd ||
                   op == OpcNopEd || op == OpcNopFd) begin
        res.cycles = 5'd4;
      end else begin
        res.status = StUnimpl;
      end
    end
    res.prog_counter = pc_q;
    res.acc = regs_q[RegA];
    res.reg_b = regs_q[RegB];
    res.reg_c = regs_q[RegC];
    res.reg_d = regs_q[RegD];
    res.reg_e = regs_q[RegE];
    res.reg_h = regs_q[RegH];
    res.reg_l = regs_q[RegL];
    res.stack_ptr = sp_q;
    res.flag_bits = flags_q;
    return res;
  endfunction

  // offer one word and wait for it to be taken
  task automatic drive_word(in_word_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.word <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic send_word(in_word_t w);
    exp_q.push_back(step_core(w));
    drive_word(w);
  endtask

  task automatic load_byte(logic [15:0] a, logic [7:0] v);
    send_word({OpLoad, a, v});
  endtask

  // write a data byte only where the instruction would read unwritten memory
  task automatic need_byte(logic [15:0] a);
    if (!mem_set[a]) load_byte(a, 8'($urandom_range(255)));
  endtask

  // sender stops until every expected word has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (exp_q.size() != 0) @(posedge clk_i);
  endtask

  // one instruction: program bytes, data bytes it reads, then execute
  task automatic random_instr();
    logic [7:0] op;
    logic [15:0] addr;
    int nops;
    int pick;
    pick = $urandom_range(99);
    if (pick < 82) begin
      op = 8'($urandom_range(127));
    end else if (pick < 90) begin
      case ($urandom_range(4))
        0: op = OpcNopCb;
        1: op = OpcNopD9;
        2: op = OpcNopDd;
        3: op = OpcNopEd;
        default: op = OpcNopFd;
      endcase
    end else begin
      op = 8'($urandom_range(255, 128));
    end
    nops = 0;
    if (op < 8'h40 && ((op[2:0] == 3'd1 && !op[3]) || (op[2:0] == 3'd2 && op[5])))
      nops = 2;
    else if (op < 8'h40 && op[2:0] == 3'd6)
      nops = 1;
    load_byte(pc_q, op);
    for (int i = 1; i <= nops; i++) load_byte(pc_q + 16'(i), 8'($urandom_range(255)));
    addr = {mem_img[pc_q + 16'd2], mem_img[pc_q + 16'd1]};
    if (op < 8'h40) begin
      if (op[2:0] == 3'd2 && op[3] && !op[5]) need_byte(pair_rd(op[5:4]));
      if (op[2:0] == 3'd2 && op[3] && op[5]) need_byte(addr);
      if (op[2:0] == 3'd2 && op[3] && op[5:4] == 2'd2) need_byte(addr + 16'd1);
      if ((op[2:0] == 3'd4 || op[2:0] == 3'd5) && op[5:3] == RegM) need_byte(hl_pair());
    end else if (op < 8'h80 && op != OpcHlt && op[2:0] == RegM) begin
      need_byte(hl_pair());
    end
    send_word({OpExec, 16'($urandom_range(65535)), 8'($urandom_range(255))});
  endtask

  task automatic random_phase(int words);
    int start;
    start = sent_cnt;
    while (sent_cnt - start < words) begin
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(3))
          0: load_byte(16'h0000, 8'($urandom_range(255)));
          1: load_byte(16'hFFFF, 8'($urandom_range(255)));
          default: load_byte(16'($urandom_range(65535)), 8'($urandom_range(255)));
        endcase
      end else begin
        random_instr();
      end
    end
  endtask

  // directed program; typed expectations where obvious
  stim_row_t dir_tab[] = '{
    {OpLoad, 16'h0000, 8'h00, 1'b1,
     StLoaded, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
     16'hF000, 5'h00, 5'd0},
    {OpExec, 16'h0000, 8'h00, 1'b1,
     StExec, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
     16'hF000, 5'h00, 5'd4},
    {OpLoad, 16'h0001, 8'h76, 1'b1,
     StLoaded, 16'h0001, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
     16'hF000, 5'h00, 5'd0},
    {OpExec, 16'hFFFF, 8'hFF, 1'b1,
     StUnimpl, 16'h0002, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
     16'hF000, 5'h00, 5'd0},
    {OpLoad, 16'h0002, 8'h37, 1'b1,
     StLoaded, 16'h0002, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
     16'hF000, 5'h00, 5'd0},
    {OpExec, 16'h0000, 8'h00, 1'b1,
     StExec, 16'h0003, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
     16'hF000, 5'h01, 5'd4},
    {OpLoad, 16'hFFFF, 8'hFF, 1'b1,
     StLoaded, 16'h0003, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
     16'hF000, 5'h01, 5'd0},
    // lxi h,0ffffh then inx h wraps to zero
    {OpLoad, 16'h0003, 8'h21, 1'b0, NoWant},
    {OpLoad, 16'h0004, 8'hFF, 1'b0, NoWant},
    {OpLoad, 16'h0005, 8'hFF, 1'b0, NoWant},
    {OpExec, 16'h0000, 8'h00, 1'b0, NoWant},
    {OpLoad, 16'h0006, 8'h23, 1'b0, NoWant},
    {OpExec, 16'h0000, 8'h00, 1'b0, NoWant},
    // mvi a,9bh then daa with both corrections
    {OpLoad, 16'h0007, 8'h3E, 1'b0, NoWant},
    {OpLoad, 16'h0008, 8'h9B, 1'b0, NoWant},
    {OpExec, 16'h0000, 8'h00, 1'b0, NoWant},
    {OpLoad, 16'h0009, 8'h27, 1'b0, NoWant},
    {OpExec, 16'h0000, 8'h00, 1'b0, NoWant},
    // dad h, unimplemented high opcode, undocumented nop
    {OpLoad, 16'h000A, 8'h29, 1'b0, NoWant},
    {OpExec, 16'h0000, 8'h00, 1'b0, NoWant},
    {OpLoad, 16'h000B, 8'h80, 1'b0, NoWant},
    {OpExec, 16'h0000, 8'h00, 1'b0, NoWant},
    {OpLoad, 16'h000C, 8'hCB, 1'b0, NoWant},
    {OpExec, 16'h0000, 8'h00, 1'b0, NoWant},
    // dcr b from zero borrows out of the low nibble
    {OpLoad, 16'h000D, 8'h05, 1'b0, NoWant},
    {OpExec, 16'h0000, 8'h00, 1'b0, NoWant}
  };

  // result receiver with random and long stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (stall_req) begin
        stall_left = LongStall;
        stall_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic cmp_field(string nm, logic [15:0] e, logic [15:0] g);
    if (e !== g) begin
      mism_cnt++;
      if (mism_cnt <= 10) $display("mismatch %s: expected %h got %h", nm, e, g);
    end
  endtask

  // compare each returned word with the oldest expectation
  always @(posedge clk_i) begin
    out_word_t e, g;
    if (rst_ni && out_if.valid && out_if.ready) begin
      g = out_if.word;
      if (exp_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10) $display("unexpected result word %h", g);
      end else begin
        e = exp_q.pop_front();
        cmp_field("status", 16'(e.status), 16'(g.status));
        cmp_field("prog_counter", e.prog_counter, g.prog_counter);
        cmp_field("acc", 16'(e.acc), 16'(g.acc));
        cmp_field("reg_b", 16'(e.reg_b), 16'(g.reg_b));
        cmp_field("reg_c", 16'(e.reg_c), 16'(g.reg_c));
        cmp_field("reg_d", 16'(e.reg_d), 16'(g.reg_d));
        cmp_field("reg_e", 16'(e.reg_e), 16'(g.reg_e));
        cmp_field("reg_h", 16'(e.reg_h), 16'(g.reg_h));
        cmp_field("reg_l", 16'(e.reg_l), 16'(g.reg_l));
        cmp_field("stack_ptr", e.stack_ptr, g.stack_ptr);
        cmp_field("flag_bits", 16'(e.flag_bits), 16'(g.flag_bits));
        cmp_field("cycles", 16'(e.cycles), 16'(g.cycles));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("i8080_core_subset_step_unit verification failed");
      $finish;
    end
  end

  initial begin
    in_if.valid <= 1'b0;
    in_if.word <= '0;
    pc_q = 16'h0000;
    sp_q = SpReset;
    flags_q = 5'h00;
    for (int i = 0; i < 8; i++) regs_q[i] = 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_idle_pct = 14;
    recv_idle_pct = 86;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].fixed) begin
        void'(step_core(dir_tab[i].w));
        exp_q.push_back(dir_tab[i].want);
        drive_word(dir_tab[i].w);
      end else begin
        send_word(dir_tab[i].w);
      end
    end
    drain();

    random_phase(RandWords / 3);
    drain();
    send_idle_pct = 86;
    recv_idle_pct = 14;
    random_phase(RandWords / 3);
    drain();

    // no idling; the receiver first holds off so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_req = 1'b1;
    random_phase(RandWords / 3);
    drain();
    repeat (20) @(posedge clk_i);

    if (mism_cnt == 0 && exp_q.size() == 0) begin
      $display("i8080_core_subset_step_unit verification clean");
    end else begin
      $display("i8080_core_subset_step_unit verification failed");
    end
    $finish;
  end

endmodule
